@@ rtl/sha256_pkg.sv @@
// Shared types, constants and round functions for the SHA-256 stream hasher.
package sha256_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_UPDATE,
    ST_PAD,
    ST_OUT
  } state_t;

  typedef logic [7:0][31:0] hash_t;

  typedef struct packed {
    logic       shift_byte;
    logic       shift_word;
    logic [7:0] byte_in;
  } sched_ctrl_t;

  typedef struct packed {
    logic       init;
    logic       step;
    logic [5:0] round;
  } round_ctrl_t;

  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [7:0] PAD_ZERO = 8'h00;

  // Element 0 holds the first initial word (a).
  localparam hash_t HASH_INIT = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ (x >> 10);
  endfunction

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

endpackage

@@ rtl/sha256_sched.sv @@
// Block buffer and rolling message schedule: byte loading and word expansion.
module sha256_sched (
  input  logic                     clk,
  input  sha256_pkg::sched_ctrl_t  ctrl,
  output logic [31:0]              w
);
  import sha256_pkg::*;

  // win[0] is the oldest word; bytes enter at the low end of win[15].
  logic [15:0][31:0] win;
  logic [31:0]       w_new;

  assign w_new = win[0] + small_sigma0(win[1]) + win[9] + small_sigma1(win[14]);
  assign w     = win[0];

  always_ff @(posedge clk) begin
    if (ctrl.shift_byte) begin
      for (int i = 0; i < 15; i++) begin
        win[i] <= {win[i][23:0], win[i+1][31:24]};
      end
      win[15] <= {win[15][23:0], ctrl.byte_in};
    end else if (ctrl.shift_word) begin
      for (int i = 0; i < 15; i++) begin
        win[i] <= win[i+1];
      end
      win[15] <= w_new;
    end
  end

endmodule

@@ rtl/sha256_round.sv @@
// Working variables a..h and the shared compression round unit.
module sha256_round (
  input  logic                     clk,
  input  sha256_pkg::round_ctrl_t  ctrl,
  input  sha256_pkg::hash_t        hash_in,
  input  logic [31:0]              w,
  output sha256_pkg::hash_t        vars
);
  import sha256_pkg::*;

  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] ch;
  logic [31:0] mj;

  assign ch = (vars[4] & vars[5]) ^ (~vars[4] & vars[6]);
  assign mj = (vars[0] & vars[1]) ^ (vars[0] & vars[2]) ^ (vars[1] & vars[2]);
  assign t1 = vars[7] + big_sigma1(vars[4]) + ch + ROUND_K[ctrl.round] + w;
  assign t2 = big_sigma0(vars[0]) + mj;

  always_ff @(posedge clk) begin
    if (ctrl.init) begin
      vars <= hash_in;
    end else if (ctrl.step) begin
      vars[7] <= vars[6];
      vars[6] <= vars[5];
      vars[5] <= vars[4];
      vars[4] <= vars[3] + t1;
      vars[3] <= vars[2];
      vars[2] <= vars[1];
      vars[1] <= vars[0];
      vars[0] <= t1 + t2;
    end
  end

endmodule

@@ rtl/sha256_stream_hasher.sv @@
// SHA-256 stream hasher: at most one message byte per input item, 256-bit digest as four 64-bit items.
// Usage: the input side takes one byte per cycle while a block fills; the 64th byte of a
// block starts a compression that runs one round per cycle on a single shared round unit,
// so the block stalls input for its 64 rounds plus the hash update. On the end item the
// padding (0x80 mark, zeros, 64-bit big-endian bit length) is fed through the same byte
// path at one byte per cycle, then the last one or two blocks are compressed. The digest
// leaves as four items, word_number 0 to 3, most significant digest bytes first, and
// input is accepted again after the fourth.
module sha256_stream_hasher (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte
  input  logic        s_axis_tuser,   // byte_present
  input  logic        s_axis_tlast,   // end_of_message
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // digest_word
  output logic [1:0]  m_axis_tuser,   // word_number
  output logic        m_axis_tlast    // last_word
);
  import sha256_pkg::*;

  state_t      state;
  state_t      state_next;
  hash_t       hash;
  hash_t       vars;
  logic [5:0]  fill;
  logic [63:0] bits;
  logic [5:0]  round_cnt;
  logic [1:0]  word_cnt;
  logic        pad_first;
  logic        two_block;
  logic        last_blk;
  logic        finishing;

  sched_ctrl_t sched_ctrl;
  round_ctrl_t round_ctrl;
  logic [31:0] w;

  logic        in_acc;
  logic        out_acc;
  logic        fill_last;
  logic        tb_eff;
  logic        len_region;
  logic [7:0]  len_byte;
  logic [7:0]  pad_byte;
  logic        start_compress;

  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign out_acc   = m_axis_tvalid && m_axis_tready;
  assign fill_last = (fill == 6'd63);

  // Two blocks are needed when the mark lands in the length field area.
  assign tb_eff     = pad_first ? (fill[5:3] == 3'b111) : two_block;
  assign len_region = !two_block && !pad_first && (fill[5:3] == 3'b111);
  assign len_byte   = bits[{~fill[2:0], 3'b000} +: 8];
  assign pad_byte   = pad_first ? PAD_MARK : (len_region ? len_byte : PAD_ZERO);

  assign start_compress = ((state == ST_IDLE) && in_acc && s_axis_tuser && fill_last) ||
                          ((state == ST_PAD) && fill_last);

  sha256_sched u_sched (
    .clk  (clk),
    .ctrl (sched_ctrl),
    .w    (w)
  );

  sha256_round u_round (
    .clk     (clk),
    .ctrl    (round_ctrl),
    .hash_in (hash),
    .w       (w),
    .vars    (vars)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          if (s_axis_tuser && fill_last) begin
            state_next = ST_ROUND;
          end else if (s_axis_tlast) begin
            state_next = ST_PAD;
          end
        end
      end
      ST_ROUND: begin
        if (round_cnt == 6'd63) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (last_blk) begin
          state_next = ST_OUT;
        end else if (finishing) begin
          state_next = ST_PAD;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_PAD: begin
        if (fill_last) begin
          state_next = ST_ROUND;
        end
      end
      ST_OUT: begin
        if (out_acc && (word_cnt == 2'd3)) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready         = 1'b0;
    m_axis_tvalid         = 1'b0;
    sched_ctrl.shift_byte = 1'b0;
    sched_ctrl.shift_word = 1'b0;
    sched_ctrl.byte_in    = s_axis_tdata;
    round_ctrl.init       = start_compress;
    round_ctrl.step       = 1'b0;
    round_ctrl.round      = round_cnt;
    case (state)
      ST_IDLE: begin
        s_axis_tready         = 1'b1;
        sched_ctrl.shift_byte = s_axis_tvalid && s_axis_tuser;
      end
      ST_ROUND: begin
        sched_ctrl.shift_word = 1'b1;
        round_ctrl.step       = 1'b1;
      end
      ST_PAD: begin
        sched_ctrl.shift_byte = 1'b1;
        sched_ctrl.byte_in    = pad_byte;
      end
      ST_OUT: begin
        m_axis_tvalid = 1'b1;
      end
      default: ;
    endcase
  end

  assign m_axis_tdata = {hash[0], hash[1]};
  assign m_axis_tuser = word_cnt;
  assign m_axis_tlast = (word_cnt == 2'd3);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      hash      <= HASH_INIT;
      fill      <= 6'd0;
      bits      <= 64'd0;
      round_cnt <= 6'd0;
      word_cnt  <= 2'd0;
      pad_first <= 1'b0;
      two_block <= 1'b0;
      last_blk  <= 1'b0;
      finishing <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            if (s_axis_tuser) begin
              fill <= fill + 6'd1;
              bits <= bits + 64'd8;
            end
            if (s_axis_tlast) begin
              finishing <= 1'b1;
              pad_first <= 1'b1;
            end
          end
        end
        ST_ROUND: begin
          round_cnt <= round_cnt + 6'd1;
        end
        ST_UPDATE: begin
          for (int i = 0; i < 8; i++) begin
            hash[i] <= hash[i] + vars[i];
          end
        end
        ST_PAD: begin
          fill      <= fill + 6'd1;
          pad_first <= 1'b0;
          if (fill_last) begin
            last_blk  <= !tb_eff;
            two_block <= 1'b0;
          end else if (pad_first) begin
            two_block <= (fill[5:3] == 3'b111);
          end
        end
        ST_OUT: begin
          if (out_acc) begin
            word_cnt <= word_cnt + 2'd1;
            if (word_cnt == 2'd3) begin
              hash      <= HASH_INIT;
              bits      <= 64'd0;
              last_blk  <= 1'b0;
              finishing <= 1'b0;
            end else begin
              hash <= {hash[7:6], hash[7:2]};
            end
          end
        end
        default: ;
      endcase
    end
  end

  a_no_in_while_out: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !m_axis_tvalid)
    else $error("input ready while digest pending");

  a_ready_after_digest: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
    else $error("not idle after last digest item");

  a_rounds_end: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_ROUND) && (round_cnt == 6'd63)) |=> (state == ST_UPDATE))
    else $error("compression did not end after 64 rounds");

  a_block_full: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROUND) |-> (fill == 6'd0))
    else $error("compression running on a partial block");

endmodule

@@ bench/sha256_stream_hasher_tb.sv @@
// Self-checking bench for sha256_stream_hasher: random byte streams against a SHA-256 predictor.
module sha256_stream_hasher_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 5000;  // cycles with no item moving on either side
  localparam int TAIL_CYCLES = 400;
  localparam int STIM_TARGET = 410;
  localparam int LONG_HOLD = 700;
  localparam int MAX_PRINTS = 30;
  localparam int PAD_LENS [9] = '{54, 55, 56, 57, 63, 64, 65, 119, 120};

  localparam logic [31:0] SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] SHA_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef struct packed {
    logic [7:0] data;
    logic       present;
    logic       last;
    logic       drain_first;  // sender waits for all digests before offering this item
  } msg_item_t;

  typedef struct packed {
    logic [63:0] word;
    logic [1:0]  num;
    logic        last;
  } digest_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;   // data_byte
  logic        s_axis_tuser = 1'b0;    // byte_present
  logic        s_axis_tlast = 1'b0;    // end_of_message
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;           // digest_word
  logic [1:0]  m_axis_tuser;           // word_number
  logic        m_axis_tlast;           // last_word

  sha256_stream_hasher uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #10 clk = ~clk;

  // predictor state
  logic [31:0] chain_hash [8];
  logic [7:0]  msg_block [64];
  int          msg_fill;
  logic [63:0] msg_bits;

  msg_item_t    pending_items [$];
  digest_word_t digest_q [$];
  msg_item_t    offered;
  int           stim_count = 0;
  int           mismatches = 0;
  int           in_accepted = 0;
  int           idle_cycles = 0;
  bit           timed_out = 1'b0;
  int           in_seen = 0;
  bit           offering = 1'b0;
  int           in_gap = 0;
  int           in_quiet = 0;
  int           out_stall = 0;
  int           out_quiet = 0;
  bit           long_hold_done = 1'b0;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void restart_chain();
    int i;
    for (i = 0; i < 8; i++) chain_hash[i] = SHA_IV[i];
    msg_fill = 0;
    msg_bits = '0;
  endfunction

  function automatic void compress_msg_block();
    logic [31:0] w [16];
    logic [31:0] v [8];
    logic [31:0] t1, t2, g0, g1, ch, mj;
    int r;
    for (r = 0; r < 16; r++)
      w[r] = {msg_block[4*r], msg_block[4*r+1], msg_block[4*r+2], msg_block[4*r+3]};
    for (r = 0; r < 8; r++) v[r] = chain_hash[r];
    for (r = 0; r < 64; r++) begin
      if (r >= 16) begin
        g0 = rotr(w[(r-15)&15], 7) ^ rotr(w[(r-15)&15], 18) ^ (w[(r-15)&15] >> 3);
        g1 = rotr(w[(r-2)&15], 17) ^ rotr(w[(r-2)&15], 19) ^ (w[(r-2)&15] >> 10);
        w[r&15] = w[r&15] + g0 + w[(r-7)&15] + g1;
      end
      ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25)) + ch + SHA_K[r] + w[r&15];
      mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22)) + mj;
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (r = 0; r < 8; r++) chain_hash[r] = chain_hash[r] + v[r];
  endfunction

  // Feeds one accepted item through the predictor; an end item queues four digest words.
  function automatic void absorb_item(input msg_item_t it);
    digest_word_t dw;
    int k;
    if (it.present) begin
      msg_block[msg_fill] = it.data;
      msg_fill++;
      msg_bits = msg_bits + 64'd8;
      if (msg_fill == 64) begin
        compress_msg_block();
        msg_fill = 0;
      end
    end
    if (it.last) begin
      msg_block[msg_fill] = 8'h80;
      msg_fill++;
      if (msg_fill > 56) begin
        while (msg_fill < 64) begin
          msg_block[msg_fill] = 8'h00;
          msg_fill++;
        end
        compress_msg_block();
        msg_fill = 0;
      end
      while (msg_fill < 56) begin
        msg_block[msg_fill] = 8'h00;
        msg_fill++;
      end
      for (k = 0; k < 8; k++) msg_block[56+k] = msg_bits[63-8*k -: 8];
      compress_msg_block();
      for (k = 0; k < 4; k++) begin
        dw.word = {chain_hash[2*k], chain_hash[2*k+1]};
        dw.num = k[1:0];
        dw.last = (k == 3);
        digest_q.insert(digest_q.size(), dw);
      end
      restart_chain();
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatches++;
    if (mismatches <= MAX_PRINTS)
      $display("MISMATCH %s: got %h expected %h", what, got, want);
  endtask

  // Mostly short gaps, a few long ones, and now and then a run with none.
  function automatic int pick_gap(inout int quiet);
    int roll;
    roll = $urandom_range(0, 99);
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if (roll < 2) begin
      quiet = $urandom_range(30, 120);
      return 0;
    end
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(25, 80);
  endfunction

  function automatic void push_item(input logic [7:0] data, input logic present,
                                    input logic last, input logic drain);
    msg_item_t it;
    it.data = data;
    it.present = present;
    it.last = last;
    it.drain_first = drain;
    pending_items.insert(pending_items.size(), it);
    stim_count++;
  endfunction

  // Queues one message with random bytes and occasional idle items; ends on the last byte or on an empty end item.
  function automatic void queue_message(input int len, input bit byte_end, input bit drain);
    int i;
    bit end_on_byte;
    end_on_byte = byte_end && (len > 0);
    for (i = 0; i < len; i++) begin
      if ($urandom_range(0, 15) == 0)
        push_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0);
      push_item(8'($urandom_range(0, 255)), 1'b1, end_on_byte && (i == len - 1),
                drain && (i == 0));
    end
    if (!end_on_byte)
      push_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, drain && (len == 0));
  endfunction

  // sender
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (in_seen != in_accepted) begin
        in_seen = in_accepted;
        offering = 1'b0;
        in_gap = pick_gap(in_quiet);
      end
      if (!offering) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (pending_items.size() > 0 &&
                     (!pending_items[0].drain_first || digest_q.size() == 0)) begin
          offered = pending_items.pop_front();
          s_axis_tdata <= offered.data;
          s_axis_tuser <= offered.present;
          s_axis_tlast <= offered.last;
          offering = 1'b1;
        end
      end
      s_axis_tvalid <= offering;
    end
  end

  // receiver, with one long hold-off once traffic is under way
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (!long_hold_done && in_accepted >= 120) begin
        long_hold_done = 1'b1;
        out_stall = LONG_HOLD;
      end
      if (out_stall > 0) begin
        out_stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        out_stall = pick_gap(out_quiet);
      end
    end
  end

  // monitor, predictor hookup and watchdog
  always @(posedge clk) begin
    digest_word_t exp_w;
    bit moved;
    moved = 1'b0;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        moved = 1'b1;
        if (digest_q.size() == 0) begin
          report_mismatch("digest item with none expected", m_axis_tdata, '0);
        end else begin
          exp_w = digest_q.pop_front();
          if (m_axis_tdata !== exp_w.word)
            report_mismatch("digest_word", m_axis_tdata, exp_w.word);
          if (m_axis_tuser !== exp_w.num)
            report_mismatch("word_number", {62'd0, m_axis_tuser}, {62'd0, exp_w.num});
          if (m_axis_tlast !== exp_w.last)
            report_mismatch("last_word", {63'd0, m_axis_tlast}, {63'd0, exp_w.last});
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        moved = 1'b1;
        absorb_item(offered);
        in_accepted++;
      end
      if (moved) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) timed_out = 1'b1;
    end
  end

  initial begin
    int len;
    int roll;
    restart_chain();

    // directed: idle item, empty message, extreme bytes, "abc", interleaved idles
    push_item(8'hA5, 1'b0, 1'b0, 1'b0);
    push_item(8'hFF, 1'b0, 1'b1, 1'b0);
    push_item(8'h00, 1'b1, 1'b1, 1'b0);
    push_item(8'hFF, 1'b1, 1'b1, 1'b0);
    push_item(8'h5A, 1'b0, 1'b0, 1'b0);
    push_item(8'h61, 1'b1, 1'b0, 1'b0);
    push_item(8'h62, 1'b1, 1'b0, 1'b0);
    push_item(8'h63, 1'b1, 1'b1, 1'b0);
    push_item(8'h12, 1'b1, 1'b0, 1'b0);
    push_item(8'h00, 1'b0, 1'b0, 1'b0);
    push_item(8'h34, 1'b1, 1'b0, 1'b0);
    push_item(8'h00, 1'b0, 1'b1, 1'b0);
    push_item(8'h80, 1'b1, 1'b0, 1'b0);
    push_item(8'h7F, 1'b1, 1'b0, 1'b0);
    push_item(8'hFF, 1'b0, 1'b0, 1'b0);
    push_item(8'h01, 1'b1, 1'b1, 1'b0);

    // random messages, lengths biased toward the padding boundaries
    queue_message(5, 1'b1, 1'b1);
    while (stim_count < STIM_TARGET) begin
      roll = $urandom_range(0, 99);
      if (roll < 50) len = $urandom_range(0, 12);
      else if (roll < 65) len = $urandom_range(13, 50);
      else if (roll < 88) len = PAD_LENS[$urandom_range(0, 8)];
      else if (roll < 97) len = $urandom_range(100, 130);
      else len = 128;
      if (len > STIM_TARGET - stim_count) len = STIM_TARGET - stim_count;
      queue_message(len, 1'($urandom_range(0, 1)), $urandom_range(0, 9) == 0);
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (!timed_out &&
           (pending_items.size() > 0 || offering || digest_q.size() > 0))
      @(posedge clk);
    if (!timed_out)
      repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0 && !timed_out && digest_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
